/* rtl/srpm_pkg.sv */
// Package for the seeded register permute mutator: constants, record types,
// FSM state types and the per-kind source usage table.
// No dependencies.
`default_nettype none

package srpm_pkg;

  localparam int SEED_BYTES          = 32;
  localparam int MAX_INSTRUCTIONS    = 32;
  localparam int MAX_IDENTITY        = 16;
  localparam int MAX_OUTPUT_REGS_DEF = 16;
  localparam int MAX_REGISTERS_DEF   = 256;
  localparam int ISTORE_DEPTH        = 48;
  localparam int ISTORE_AW           = 6;
  localparam int IFILL_W             = 6;
  localparam int NFIELD_REGS         = 6;

  localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX2   = 64'h94d049bb133111eb;

  localparam logic       OP_INSTR  = 1'b0;
  localparam logic       OP_OUTREG = 1'b1;

  localparam logic [2:0] KIND_XOR2     = 3'd0;
  localparam logic [2:0] KIND_XOR5     = 3'd1;
  localparam logic [2:0] KIND_XORROT1  = 3'd2;
  localparam logic [2:0] KIND_ROTCOPY  = 3'd3;
  localparam logic [2:0] KIND_CHI      = 3'd4;
  localparam logic [2:0] KIND_XORINPUT = 3'd5;
  localparam logic [2:0] KIND_XORCONST = 3'd6;
  localparam logic [2:0] KIND_BAD      = 3'd7;

  localparam logic [1:0] RES_INSTR  = 2'd0;
  localparam logic [1:0] RES_OUTREG = 2'd1;
  localparam logic [1:0] RES_ERROR  = 2'd2;

  localparam logic [2:0] CFG_SEED0     = 3'd0;
  localparam logic [2:0] CFG_SEED1     = 3'd1;
  localparam logic [2:0] CFG_SEED2     = 3'd2;
  localparam logic [2:0] CFG_SEED3     = 3'd3;
  localparam logic [2:0] CFG_REG_COUNT = 3'd4;
  localparam logic [2:0] CFG_ID_COUNT  = 3'd5;

  // One stored instruction; regs[0] is the destination, regs[1..5] sources a..e.
  typedef struct packed {
    logic                              ident;
    logic [63:0]                       imm;
    logic [2:0]                        kind;
    logic [NFIELD_REGS-1:0][7:0]       regs;
  } istore_t;

  typedef struct packed {
    logic       start;
    logic       seed;
    logic [8:0] n;
  } rng_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] index;
  } rng_rsp_t;

  typedef enum logic [2:0] {
    R_IDLE,
    R_SEED,
    R_ADD,
    R_MUL1,
    R_XOR1,
    R_MUL2,
    R_XOR2,
    R_MOD
  } rng_state_e;

  typedef enum logic [4:0] {
    S_LOAD,
    S_ERR,
    S_SEED_GO,
    S_SEED_WAIT,
    S_INIT,
    S_SH_GO,
    S_SH_WAIT,
    S_SH_RD0,
    S_SH_RD1,
    S_SH_WR0,
    S_SH_WR1,
    S_ID_GO,
    S_ID_RW,
    S_ID_PGO,
    S_ID_PW,
    S_MV,
    S_MV_WR,
    S_EM_START,
    S_EM_RD,
    S_EM_CAP,
    S_EM_MAP,
    S_EM_MAPW,
    S_EM_OUT,
    S_OR_RD,
    S_OR_CAP,
    S_OR_OUT
  } mut_state_e;

  // bit k set: source k (a..e) is a register operand of this kind
  function automatic logic [4:0] used_sources(input logic [2:0] kind);
    logic [4:0] u;
    case (kind)
      KIND_XOR2:     u = 5'b00011;
      KIND_XOR5:     u = 5'b11111;
      KIND_XORROT1:  u = 5'b00011;
      KIND_ROTCOPY:  u = 5'b00001;
      KIND_CHI:      u = 5'b00111;
      KIND_XORINPUT: u = 5'b00001;
      KIND_XORCONST: u = 5'b00001;
      default:       u = 5'b00000;
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

/* rtl/srpm_rng.sv */
// Seed mixer and splitmix64 index generator; its multiplies share one 32x32
// multiplier, then a bit-serial 64-step remainder. Uses srpm_pkg.
`default_nettype none

module srpm_rng (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [3:0][63:0]      seed_i,
  input  srpm_pkg::rng_req_t    req_i,
  output srpm_pkg::rng_rsp_t    rsp_o
);
  import srpm_pkg::*;

  rng_state_e  st_q, st_d;
  logic [63:0] s_q;
  logic [5:0]  cnt_q;
  logic [1:0]  mp_q;
  logic        done_q;

  logic [63:0] z_q, acc_q, prod_q;
  logic [8:0]  n_q, rem_q;
  logic [7:0]  idx_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p, mul_c;
  logic [7:0]  sb;
  logic [63:0] x1, xn, sg;
  logic [8:0]  t, rem_n;

  assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

  // seed mixing step, state advance and remainder step
  always_comb begin
    sb = seed_i[cnt_q[4:3]][{cnt_q[2:0], 3'b000} +: 8];
    x1 = s_q ^ ({56'b0, sb} << {cnt_q[2:0], 3'b000});
    xn = x1 + GOLDEN + (x1 << 6) + (x1 >> 2);
    sg = s_q + GOLDEN;
    t  = {rem_q[7:0], z_q[63]};
    rem_n = (t >= n_q) ? (t - n_q) : t;
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      R_IDLE: begin
        if (req_i.start) begin
          st_d = req_i.seed ? R_SEED : R_ADD;
        end
      end
      R_SEED: begin
        if (cnt_q == 6'(SEED_BYTES - 1)) begin
          st_d = R_IDLE;
        end
      end
      R_ADD:  st_d = R_MUL1;
      R_MUL1: begin
        if (mp_q == 2'd3) begin
          st_d = R_XOR1;
        end
      end
      R_XOR1: st_d = R_MUL2;
      R_MUL2: begin
        if (mp_q == 2'd3) begin
          st_d = R_XOR2;
        end
      end
      R_XOR2: st_d = R_MOD;
      R_MOD: begin
        if (cnt_q == 6'd63) begin
          st_d = R_IDLE;
        end
      end
      default: st_d = R_IDLE;
    endcase
  end

  // multiplier operand select: low x low, low x high, high x low
  always_comb begin
    mul_c = (st_q == R_MUL1) ? MIX1 : MIX2;
    case (mp_q)
      2'd1: begin
        mul_a = z_q[31:0];
        mul_b = mul_c[63:32];
      end
      2'd2: begin
        mul_a = z_q[63:32];
        mul_b = mul_c[31:0];
      end
      default: begin
        mul_a = z_q[31:0];
        mul_b = mul_c[31:0];
      end
    endcase
    rsp_o.done  = done_q;
    rsp_o.index = idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= R_IDLE;
      s_q    <= '0;
      cnt_q  <= '0;
      mp_q   <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= ((st_q == R_SEED) && (cnt_q == 6'(SEED_BYTES - 1))) ||
                ((st_q == R_MOD) && (cnt_q == 6'd63));
      case (st_q)
        R_IDLE: begin
          cnt_q <= '0;
          mp_q  <= '0;
          if (req_i.start && req_i.seed) begin
            s_q <= GOLDEN;
          end
        end
        R_SEED: begin
          s_q   <= xn;
          cnt_q <= cnt_q + 6'd1;
        end
        R_ADD: s_q <= sg;
        R_MUL1, R_MUL2: mp_q <= mp_q + 2'd1;
        R_XOR2: cnt_q <= '0;
        R_MOD: cnt_q <= cnt_q + 6'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      R_IDLE: begin
        if (req_i.start) begin
          n_q <= req_i.n;
        end
      end
      R_ADD: z_q <= sg ^ (sg >> 30);
      R_MUL1, R_MUL2: begin
        case (mp_q)
          2'd0: prod_q <= mul_p;
          2'd1: begin
            acc_q  <= prod_q;
            prod_q <= mul_p;
          end
          2'd2: begin
            acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
            prod_q       <= mul_p;
          end
          default: z_q <= {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
        endcase
      end
      R_XOR1: z_q <= z_q ^ (z_q >> 27);
      R_XOR2: begin
        z_q   <= z_q ^ (z_q >> 31);
        rem_q <= '0;
      end
      R_MOD: begin
        rem_q <= rem_n;
        z_q   <= z_q << 1;
        if (cnt_q == 6'd63) begin
          idx_q <= rem_n[7:0];
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/seeded_register_permute_mutator_unit.sv */
// Top level of the seeded register permute mutator: load buffers, permutation
// memory, sequencer and result port. Uses srpm_pkg and srpm_rng.
// Loading takes one item per cycle while in_stall_o is low. After the last item
// the unit mixes the seed, initialises the table, shuffles it and inserts each
// identity; each random index draw uses the 64-step bit-serial remainder and
// the shared 32x32 multiplier. Results follow one by one, each after the
// previous one is taken. One load set at a time. Reset restores the register
// defaults and empties the buffers; memories keep their contents and are never
// read before being written.
`default_nettype none

module seeded_register_permute_mutator_unit #(
  parameter int MAX_OUTPUT_REGS = srpm_pkg::MAX_OUTPUT_REGS_DEF,
  parameter int MAX_REGISTERS   = srpm_pkg::MAX_REGISTERS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [2:0]  instr_kind_i,
  input  logic [7:0]  dst_reg_i,
  input  logic [7:0]  src_a_i,
  input  logic [7:0]  src_b_i,
  input  logic [7:0]  src_c_i,
  input  logic [7:0]  src_d_i,
  input  logic [7:0]  src_e_i,
  input  logic [63:0] imm_value_i,
  input  logic        load_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [2:0]  out_instr_kind_o,
  output logic [7:0]  out_dst_o,
  output logic [7:0]  out_a_o,
  output logic [7:0]  out_b_o,
  output logic [7:0]  out_c_o,
  output logic [7:0]  out_d_o,
  output logic [7:0]  out_e_o,
  output logic [63:0] out_imm_o,
  output logic        out_last_o
);
  import srpm_pkg::*;

  localparam int PW  = $clog2(MAX_REGISTERS);
  localparam int OW  = (MAX_OUTPUT_REGS > 1) ? $clog2(MAX_OUTPUT_REGS) : 1;
  localparam int OFW = $clog2(MAX_OUTPUT_REGS + 1);

  // configuration
  logic [3:0][63:0] seed_q;
  logic [8:0]       rc_q;
  logic [4:0]       ic_q;

  // control
  mut_state_e          state_q, state_d;
  logic [IFILL_W-1:0]  ifill_q;
  logic [OFW-1:0]      ofill_q;
  logic                err_q;
  logic [8:0]          cnt_q;
  logic [IFILL_W-1:0]  e_q;
  logic [2:0]          fk_q;
  logic [4:0]          id_q;
  logic [OFW-1:0]      ok_q;

  // payload
  logic [7:0]          j_q, tmp_q;
  logic [IFILL_W-1:0]  pos_q;
  istore_t             wk_q;
  logic [7:0]          oreg_q [MAX_OUTPUT_REGS];

  // memories
  logic [7:0]          perm_mem [MAX_REGISTERS];
  logic [PW-1:0]       perm_raddr, perm_waddr;
  logic [7:0]          perm_wdata, perm_rd_q;
  logic                perm_we;
  istore_t             istore_mem [ISTORE_DEPTH];
  logic [ISTORE_AW-1:0] is_raddr, is_waddr;
  istore_t             is_wdata, is_rd_q;
  logic                is_we;

  rng_req_t rng_req;
  rng_rsp_t rng_rsp;

  logic                        in_fire, out_fire;
  logic [NFIELD_REGS-1:0][7:0] in_regs;
  logic [4:0]                  in_used;
  logic                        load_err, cfg_err;
  logic [7:0]                  need_mask;
  logic                        need;
  logic                        em_more, or_more;

  srpm_rng u_rng (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seed_i (seed_q),
    .req_i  (rng_req),
    .rsp_o  (rng_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
    perm_rd_q <= perm_mem[perm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (is_we) begin
      istore_mem[is_waddr] <= is_wdata;
    end
    is_rd_q <= istore_mem[is_raddr];
  end

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;
  assign in_regs  = {src_e_i, src_d_i, src_c_i, src_b_i, src_a_i, dst_reg_i};
  assign in_used  = used_sources(instr_kind_i);

  always_comb begin
    load_err = 1'b0;
    if (opcode_i == OP_INSTR) begin
      if (instr_kind_i == KIND_BAD || {1'b0, dst_reg_i} >= rc_q) begin
        load_err = 1'b1;
      end
      for (int k = 0; k < 5; k++) begin
        if (in_used[k] && {1'b0, in_regs[k+1]} >= rc_q) begin
          load_err = 1'b1;
        end
      end
      if (ifill_q >= IFILL_W'(MAX_INSTRUCTIONS)) begin
        load_err = 1'b1;
      end
    end else begin
      if ({1'b0, dst_reg_i} >= rc_q || ofill_q >= OFW'(MAX_OUTPUT_REGS)) begin
        load_err = 1'b1;
      end
    end
    cfg_err = (rc_q > 9'(MAX_REGISTERS)) || (ic_q > 5'(MAX_IDENTITY)) ||
              (ic_q != 5'd0 && rc_q == 9'd0);
    need_mask = {2'b00, used_sources(wk_q.kind), 1'b1};
    need      = !wk_q.ident && (fk_q < 3'd6) && need_mask[fk_q];
    em_more   = ({1'b0, e_q} + 7'd1) < {1'b0, ifill_q};
    or_more   = ({1'b0, ok_q} + 1'b1) < {1'b0, ofill_q};
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD: begin
        if (in_fire && load_last_i) begin
          state_d = (err_q || load_err || cfg_err) ? S_ERR : S_SEED_GO;
        end
      end
      S_ERR: begin
        if (out_fire) begin
          state_d = S_LOAD;
        end
      end
      S_SEED_GO:   state_d = S_SEED_WAIT;
      S_SEED_WAIT: begin
        if (rng_rsp.done) begin
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        if (cnt_q == rc_q) begin
          state_d = (rc_q > 9'd1) ? S_SH_GO : S_ID_GO;
        end
      end
      S_SH_GO:   state_d = S_SH_WAIT;
      S_SH_WAIT: begin
        if (rng_rsp.done) begin
          state_d = S_SH_RD0;
        end
      end
      S_SH_RD0: state_d = S_SH_RD1;
      S_SH_RD1: state_d = S_SH_WR0;
      S_SH_WR0: state_d = S_SH_WR1;
      S_SH_WR1: state_d = (cnt_q > 9'd2) ? S_SH_GO : S_ID_GO;
      S_ID_GO:  state_d = (id_q == ic_q) ? S_EM_START : S_ID_RW;
      S_ID_RW: begin
        if (rng_rsp.done) begin
          state_d = S_ID_PGO;
        end
      end
      S_ID_PGO: state_d = S_ID_PW;
      S_ID_PW: begin
        if (rng_rsp.done) begin
          state_d = (ifill_q >= IFILL_W'(ISTORE_DEPTH)) ? S_EM_START : S_MV;
        end
      end
      S_MV:       state_d = (e_q == pos_q) ? S_ID_GO : S_MV_WR;
      S_MV_WR:    state_d = S_MV;
      S_EM_START: state_d = (ifill_q != '0) ? S_EM_RD : S_OR_RD;
      S_EM_RD:    state_d = S_EM_CAP;
      S_EM_CAP:   state_d = S_EM_MAP;
      S_EM_MAP: begin
        if (fk_q == 3'd6) begin
          state_d = S_EM_OUT;
        end else if (need) begin
          state_d = S_EM_MAPW;
        end
      end
      S_EM_MAPW: state_d = S_EM_MAP;
      S_EM_OUT: begin
        if (out_fire) begin
          if (em_more) begin
            state_d = S_EM_RD;
          end else if (ofill_q != '0) begin
            state_d = S_OR_RD;
          end else begin
            state_d = S_LOAD;
          end
        end
      end
      S_OR_RD:  state_d = S_OR_CAP;
      S_OR_CAP: state_d = S_OR_OUT;
      S_OR_OUT: begin
        if (out_fire) begin
          state_d = or_more ? S_OR_RD : S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // outputs, memory ports and unit requests
  always_comb begin
    in_stall_o = (state_q != S_LOAD);
    perm_raddr = wk_q.regs[0][PW-1:0];
    perm_waddr = cnt_q[PW-1:0];
    perm_wdata = cnt_q[7:0];
    perm_we    = 1'b0;
    is_raddr   = e_q;
    is_waddr   = ifill_q;
    is_wdata   = istore_t'{ident: 1'b0, imm: imm_value_i, kind: instr_kind_i,
                           regs: in_regs};
    is_we      = 1'b0;
    rng_req    = '{start: 1'b0, seed: 1'b0, n: rc_q};

    out_valid_o      = 1'b0;
    result_kind_o    = RES_INSTR;
    out_instr_kind_o = '0;
    out_dst_o        = '0;
    out_a_o          = '0;
    out_b_o          = '0;
    out_c_o          = '0;
    out_d_o          = '0;
    out_e_o          = '0;
    out_imm_o        = '0;
    out_last_o       = 1'b0;

    case (state_q)
      S_LOAD: begin
        is_we = in_fire && (opcode_i == OP_INSTR) &&
                (ifill_q < IFILL_W'(MAX_INSTRUCTIONS));
      end
      S_ERR: begin
        out_valid_o   = 1'b1;
        result_kind_o = RES_ERROR;
        out_last_o    = 1'b1;
      end
      S_SEED_GO: begin
        rng_req.start = 1'b1;
        rng_req.seed  = 1'b1;
      end
      S_INIT: perm_we = (cnt_q != rc_q);
      S_SH_GO: begin
        rng_req.start = 1'b1;
        rng_req.n     = cnt_q;
      end
      S_SH_RD0: perm_raddr = PW'(cnt_q - 9'd1);
      S_SH_RD1: perm_raddr = j_q[PW-1:0];
      S_SH_WR0: begin
        perm_we    = 1'b1;
        perm_waddr = PW'(cnt_q - 9'd1);
        perm_wdata = perm_rd_q;
      end
      S_SH_WR1: begin
        perm_we    = 1'b1;
        perm_waddr = j_q[PW-1:0];
        perm_wdata = tmp_q;
      end
      S_ID_GO: rng_req.start = (id_q != ic_q);
      S_ID_PGO: begin
        rng_req.start = 1'b1;
        rng_req.n     = {3'b0, ifill_q} + 9'd1;
      end
      S_MV: begin
        is_raddr = e_q - 1'b1;
        if (e_q == pos_q) begin
          is_we    = 1'b1;
          is_waddr = pos_q;
          is_wdata = istore_t'{ident: 1'b1, imm: 64'd0, kind: KIND_XORCONST,
                               regs: {32'd0, j_q, j_q}};
        end
      end
      S_MV_WR: begin
        is_we    = 1'b1;
        is_waddr = e_q;
        is_wdata = is_rd_q;
      end
      S_EM_MAP: perm_raddr = wk_q.regs[fk_q][PW-1:0];
      S_EM_OUT: begin
        out_valid_o      = 1'b1;
        result_kind_o    = RES_INSTR;
        out_instr_kind_o = wk_q.kind;
        out_dst_o        = wk_q.regs[0];
        out_a_o          = wk_q.regs[1];
        out_b_o          = wk_q.regs[2];
        out_c_o          = wk_q.regs[3];
        out_d_o          = wk_q.regs[4];
        out_e_o          = wk_q.regs[5];
        out_imm_o        = wk_q.imm;
        out_last_o       = !em_more && (ofill_q == '0);
      end
      S_OR_RD: perm_raddr = oreg_q[ok_q[OW-1:0]][PW-1:0];
      S_OR_OUT: begin
        out_valid_o   = 1'b1;
        result_kind_o = RES_OUTREG;
        out_dst_o     = wk_q.regs[0];
        out_last_o    = !or_more;
      end
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      rc_q   <= 9'd256;
      ic_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SEED0, CFG_SEED1, CFG_SEED2, CFG_SEED3: seed_q[cfg_index_i[1:0]] <= cfg_wdata_i;
        CFG_REG_COUNT: rc_q <= cfg_wdata_i[8:0];
        CFG_ID_COUNT:  ic_q <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  // sequencer counters and fills
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      ifill_q <= '0;
      ofill_q <= '0;
      err_q   <= 1'b0;
      cnt_q   <= '0;
      e_q     <= '0;
      fk_q    <= '0;
      id_q    <= '0;
      ok_q    <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_LOAD: begin
          if (in_fire) begin
            if (load_last_i && (err_q || load_err || cfg_err)) begin
              // drop the set; the error item is all that is reported
              ifill_q <= '0;
              ofill_q <= '0;
              err_q   <= 1'b0;
            end else begin
              if (opcode_i == OP_INSTR) begin
                if (ifill_q < IFILL_W'(MAX_INSTRUCTIONS)) begin
                  ifill_q <= ifill_q + 1'b1;
                end
              end else if (ofill_q < OFW'(MAX_OUTPUT_REGS)) begin
                ofill_q <= ofill_q + 1'b1;
              end
              err_q <= err_q || load_err;
            end
          end
        end
        S_SEED_GO: begin
          cnt_q <= '0;
          id_q  <= '0;
        end
        S_INIT: begin
          if (cnt_q != rc_q) begin
            cnt_q <= cnt_q + 9'd1;
          end
        end
        S_SH_WR1: cnt_q <= cnt_q - 9'd1;
        S_ID_PW: e_q <= ifill_q;
        S_MV: begin
          if (e_q == pos_q) begin
            ifill_q <= ifill_q + 1'b1;
            id_q    <= id_q + 5'd1;
          end
        end
        S_MV_WR: e_q <= e_q - 1'b1;
        S_EM_START: begin
          e_q  <= '0;
          ok_q <= '0;
        end
        S_EM_CAP: fk_q <= '0;
        S_EM_MAP: begin
          if (fk_q != 3'd6 && !need) begin
            fk_q <= fk_q + 3'd1;
          end
        end
        S_EM_MAPW: fk_q <= fk_q + 3'd1;
        S_EM_OUT: begin
          if (out_fire) begin
            e_q <= e_q + 1'b1;
            if (!em_more && ofill_q == '0) begin
              ifill_q <= '0;
            end
          end
        end
        S_OR_OUT: begin
          if (out_fire) begin
            ok_q <= ok_q + 1'b1;
            if (!or_more) begin
              ifill_q <= '0;
              ofill_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // working registers and output register store
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_LOAD: begin
        if (in_fire && opcode_i == OP_OUTREG && ofill_q < OFW'(MAX_OUTPUT_REGS)) begin
          oreg_q[ofill_q[OW-1:0]] <= dst_reg_i;
        end
      end
      S_SH_WAIT, S_ID_RW: begin
        if (rng_rsp.done) begin
          j_q <= rng_rsp.index;
        end
      end
      S_ID_PW: begin
        if (rng_rsp.done) begin
          pos_q <= rng_rsp.index[IFILL_W-1:0];
        end
      end
      S_SH_RD1:  tmp_q <= perm_rd_q;
      S_EM_CAP:  wk_q <= is_rd_q;
      S_EM_MAPW: wk_q.regs[fk_q] <= perm_rd_q;
      S_OR_CAP:  wk_q.regs[0] <= perm_rd_q;
      default: ;
    endcase
  end

endmodule

`default_nettype wire
